/* rtl/mcrb_pkg.sv */
// ----------------------------------------------------------------------------
// mcrb_pkg
// Types and constants shared by the multi-channel receive ring buffer.
// ----------------------------------------------------------------------------
package mcrb_pkg;

  // Widest pointer the buffer depth range can call for (depth up to 4096)
  localparam int PTR_MAX_W = 12;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e_t;

  typedef struct packed {
    op_e_t       op;
    logic [2:0]  channel;
    logic [7:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [7:0]  data_out;
    logic        data_valid;
    logic        push_dropped;
    logic [7:0]  level;
    logic        overflow_flag;
  } out_item_t;

  // Result of one operation, waiting for the byte store read data
  typedef struct packed {
    logic [2:0]  channel;
    logic        data_valid;
    logic        push_dropped;
    logic [7:0]  level;
    logic        overflow_flag;
  } stage_t;

  // Byte store access for one accepted item
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [2:0]           channel;
    logic [PTR_MAX_W-1:0] wr_ptr;
    logic [PTR_MAX_W-1:0] rd_ptr;
    logic [7:0]           wr_data;
  } store_req_t;

endpackage

/* rtl/mcrb_ctrl.sv */
// ----------------------------------------------------------------------------
// mcrb_ctrl
// Per-channel pointers and overflow flags; decodes one operation per cycle, updating state only on accept.
// ----------------------------------------------------------------------------
module mcrb_ctrl #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  mcrb_pkg::in_item_t  item,
  output mcrb_pkg::stage_t    result,
  output mcrb_pkg::store_req_t req
);

  localparam int PW  = $clog2(DEPTH);
  localparam int FW  = PW + 1;
  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [PW-1:0] wr_ptr_r [CHANNELS];
  logic [PW-1:0] rd_ptr_r [CHANNELS];
  logic          ovf_r    [CHANNELS];

  logic           ch_ok;
  logic [CIW-1:0] ch_idx;
  logic [PW-1:0]  wp, rp, wp_inc, rp_inc, wp_nxt, rp_nxt;
  logic           ovf, ovf_nxt;
  logic [FW-1:0]  sum;
  logic [PW-1:0]  fill, fill_after;
  logic           full, empty;
  logic           push_ok, dropped, hit;

  always_comb begin
    ch_ok  = 32'(item.channel) < 32'(CHANNELS);
    ch_idx = CIW'(item.channel);
    wp     = wr_ptr_r[ch_idx];
    rp     = rd_ptr_r[ch_idx];
    ovf    = ovf_r[ch_idx];

    // level = (wp - rp) mod DEPTH
    sum  = FW'(wp) + FW'(DEPTH) - FW'(rp);
    fill = (sum >= FW'(DEPTH)) ? PW'(sum - FW'(DEPTH)) : PW'(sum);
    full  = (fill == PW'(DEPTH - 1));
    empty = (fill == '0);

    wp_inc = (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
    rp_inc = (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;

    wp_nxt     = wp;
    rp_nxt     = rp;
    ovf_nxt    = ovf;
    fill_after = fill;
    push_ok    = 1'b0;
    dropped    = 1'b0;
    hit        = 1'b0;

    case (item.op)
      mcrb_pkg::OP_PUSH: begin
        if (!full) begin
          push_ok    = 1'b1;
          wp_nxt     = wp_inc;
          fill_after = fill + 1'b1;
        end else begin
          dropped = 1'b1;
        end
        if (fill_after == PW'(DEPTH - 1)) ovf_nxt = 1'b1;
      end
      mcrb_pkg::OP_POP: begin
        if (!empty) begin
          hit        = 1'b1;
          rp_nxt     = rp_inc;
          fill_after = fill - 1'b1;
        end
      end
      mcrb_pkg::OP_PEEK: begin
        hit = !empty;
      end
      mcrb_pkg::OP_CLEAR: begin
        wp_nxt     = '0;
        rp_nxt     = '0;
        ovf_nxt    = 1'b0;
        fill_after = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase

    result.channel       = item.channel;
    result.data_valid    = ch_ok && hit;
    result.push_dropped  = ch_ok && dropped;
    result.overflow_flag = ch_ok && ovf_nxt;
    if (!ch_ok) result.level = 8'd0;
    else if (32'(fill_after) > 32'd255) result.level = 8'hFF;
    else result.level = 8'(fill_after);

    req.wr_en   = accept && ch_ok && push_ok;
    req.rd_en   = accept && ch_ok && hit;
    req.channel = item.channel;
    req.wr_ptr  = mcrb_pkg::PTR_MAX_W'(wp);
    req.rd_ptr  = mcrb_pkg::PTR_MAX_W'(rp);
    req.wr_data = item.data_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_ptr_r[i] <= '0;
        rd_ptr_r[i] <= '0;
        ovf_r[i]    <= 1'b0;
      end
    end else if (accept && ch_ok) begin
      wr_ptr_r[ch_idx] <= wp_nxt;
      rd_ptr_r[ch_idx] <= rp_nxt;
      ovf_r[ch_idx]    <= ovf_nxt;
    end
  end

endmodule

/* rtl/mcrb_store.sv */
// ----------------------------------------------------------------------------
// mcrb_store
// Byte store for all channels: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcrb_store #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = 256
) (
  input  logic                 clk,
  input  mcrb_pkg::store_req_t req,
  output logic [7:0]           rd_data
);

  localparam int AW  = $clog2(CHANNELS * DEPTH);
  localparam int PW  = $clog2(DEPTH);

  logic [7:0]    mem [CHANNELS * DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] base, waddr, raddr;

  always_comb begin
    base  = AW'(req.channel) * AW'(DEPTH);
    waddr = base + AW'(req.wr_ptr[PW-1:0]);
    raddr = base + AW'(req.rd_ptr[PW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[waddr] <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/multi_channel_rx_ring_buffer.sv */
// ----------------------------------------------------------------------------
// multi_channel_rx_ring_buffer
// Per-channel receive ring buffers with sticky overflow flags.
// ----------------------------------------------------------------------------
//
//   port group   dir   role
//   in_*         in    operation item: op, channel, data_in; in_stall is an output
//   out_*        out   result item: one per operation; out_stall is an input
//
// Flow: one operation per cycle while out_stall stays low; an accepted item's
//   result passes the read stage (byte store read), then the output register.
// Pointers and flags update at the accepting edge, so the next item sees them.
// Reset: synchronous, active low; clears pointers, flags and valids. The byte
//   store holds garbage until written and needs no clearing pass.
// Stalls: out_stall holds the output register; in_stall rises only when both
//   the read stage and the output register are full and the output is stalled.
// ----------------------------------------------------------------------------
module multi_channel_rx_ring_buffer #(
  parameter int CHANNELS = 8,
  parameter int DEPTH    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcrb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mcrb_pkg::out_item_t out_item
);

  logic                 accept;
  logic                 advance;
  mcrb_pkg::stage_t     result;
  mcrb_pkg::store_req_t req;
  logic [7:0]           rd_data;

  // Read stage: operation result waiting on the byte store read
  logic                 s1_valid_r, s1_valid_nxt;
  mcrb_pkg::stage_t     s1_r;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  mcrb_pkg::out_item_t  out_item_r, out_item_nxt;

  // Advance the read stage whenever the output register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  mcrb_ctrl #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .result (result),
    .req    (req)
  );

  mcrb_store #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = accept || (s1_valid_r && !advance);

    // Drop the byte unless the pop or peek found one
    out_item_nxt.channel_out   = s1_r.channel;
    out_item_nxt.data_out      = s1_r.data_valid ? rd_data : 8'd0;
    out_item_nxt.data_valid    = s1_r.data_valid;
    out_item_nxt.push_dropped  = s1_r.push_dropped;
    out_item_nxt.level         = s1_r.level;
    out_item_nxt.overflow_flag = s1_r.overflow_flag;

    if (advance) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) s1_r <= result;
    if (advance) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost from read stage");

  a_drop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.push_dropped) |->
      (out_item_r.overflow_flag && !out_item_r.data_valid))
    else $error("dropped push without overflow flag");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.data_valid) |-> (out_item_r.data_out == 8'd0))
    else $error("data_out nonzero without a byte");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-channel receive ring buffer.
// Drives push, pop, peek and clear items with random gaps on both sides. A
// behavioral ring model in the bench predicts each result, and the monitor
// checks every field of every result in order.
// ----------------------------------------------------------------------------
module testbench;

  // Geometry of the instance under test
  localparam int NUM_CH     = 8;
  localparam int RING_DEPTH = 256;

  // Stimulus size and run limits
  localparam int RANDOM_OPS  = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;   // results pass the read stage and output register
  localparam int MAX_WAIT    = 18;
  localparam int REPORT_CAP  = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mcrb_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mcrb_pkg::out_item_t out_item;

  multi_channel_rx_ring_buffer #(
    .CHANNELS(NUM_CH),
    .DEPTH   (RING_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring model: per-channel byte slots, pointers and sticky overflow bits.
  // One slot of each ring stays unused, so a ring holds RING_DEPTH-1 bytes.
  // --------------------------------------------------------------------------
  logic [7:0]  ring_bytes [NUM_CH][RING_DEPTH];
  int unsigned ring_wr [NUM_CH] = '{default: 0};
  int unsigned ring_rd [NUM_CH] = '{default: 0};
  bit          ring_ovf [NUM_CH] = '{default: 1'b0};

  // Items waiting for the driver, and results waiting for the monitor
  mcrb_pkg::in_item_t  op_queue [$];
  mcrb_pkg::out_item_t results_due [$];

  int unsigned ops_total    = 0;
  int unsigned ops_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count  = 0;

  // Coverage tallies for the closing summary
  int unsigned n_dropped = 0;
  int unsigned n_empty_reads = 0;
  int unsigned n_good_reads = 0;
  int unsigned n_clears = 0;
  int unsigned n_full_seen = 0;

  function automatic int unsigned ring_fill(int unsigned ch);
    return (ring_wr[ch] + RING_DEPTH - ring_rd[ch]) % RING_DEPTH;
  endfunction

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one operation to the model and return the result it must produce
  function automatic mcrb_pkg::out_item_t predict_ring_op(mcrb_pkg::in_item_t it);
    mcrb_pkg::out_item_t res;
    int unsigned         ch;
    int unsigned         fill;
    res = '0;
    ch  = 32'(it.channel);
    res.channel_out = it.channel;
    if (ch < NUM_CH) begin
      fill = ring_fill(ch);
      case (it.op)
        mcrb_pkg::OP_PUSH: begin
          if (fill < RING_DEPTH - 1) begin
            ring_bytes[ch][ring_wr[ch]] = it.data_in;
            ring_wr[ch] = ring_next(ring_wr[ch]);
          end else begin
            res.push_dropped = 1'b1;
            n_dropped++;
          end
          if (ring_fill(ch) == RING_DEPTH - 1) begin
            ring_ovf[ch] = 1'b1;
            n_full_seen++;
          end
        end
        mcrb_pkg::OP_POP, mcrb_pkg::OP_PEEK: begin
          if (fill != 0) begin
            res.data_out   = ring_bytes[ch][ring_rd[ch]];
            res.data_valid = 1'b1;
            n_good_reads++;
            if (it.op == mcrb_pkg::OP_POP) ring_rd[ch] = ring_next(ring_rd[ch]);
          end else begin
            n_empty_reads++;
          end
        end
        default: begin
          ring_wr[ch]  = 0;
          ring_rd[ch]  = 0;
          ring_ovf[ch] = 1'b0;
          n_clears++;
        end
      endcase
      fill = ring_fill(ch);
      res.level = (fill > 255) ? 8'd255 : fill[7:0];
      res.overflow_flag = ring_ovf[ch];
    end
    return res;
  endfunction

  // Number of idle cycles before the next item; long quiet stretches give
  // back-to-back traffic with no idling at all.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void add_op(mcrb_pkg::op_e_t op, int unsigned ch, int unsigned data);
    mcrb_pkg::in_item_t it;
    it.op      = op;
    it.channel = ch[2:0];
    it.data_in = data[7:0];
    op_queue.push_back(it);
  endfunction

  function automatic mcrb_pkg::op_e_t mixed_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return mcrb_pkg::OP_PUSH;
    if (r < 80) return mcrb_pkg::OP_POP;
    if (r < 94) return mcrb_pkg::OP_PEEK;
    return mcrb_pkg::OP_CLEAR;
  endfunction

  function automatic void cmp_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present items from op_queue, idling for a drawn number of cycles
  // after each one. A stalled item holds its payload until accepted.
  // --------------------------------------------------------------------------
  int unsigned src_wait = 0;
  bit          src_quiet = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_wait <= 0;
    end else begin
      // Accepted item: advance the model and queue the result it owes
      if (in_valid && !in_stall) begin
        results_due.push_back(predict_ring_op(in_item));
        ops_accepted++;
      end
      // Slot is free after this edge: idle, launch the next item, or drop valid
      if (!in_valid || !in_stall) begin
        if (src_wait > 0) begin
          src_wait <= src_wait - 1;
          in_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          in_item  <= op_queue.pop_front();
          in_valid <= 1'b1;
          src_wait <= draw_wait(src_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, compare each against the oldest prediction, then
  // stall for a drawn number of cycles before the next one.
  // --------------------------------------------------------------------------
  int unsigned         sink_hold = 0;
  bit                  sink_quiet = 1'b0;
  int unsigned         hold_draw;
  mcrb_pkg::out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else if (out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_item);
      end else begin
        want = results_due.pop_front();
        cmp_field("channel_out",   want.channel_out,   out_item.channel_out);
        cmp_field("data_out",      want.data_out,      out_item.data_out);
        cmp_field("data_valid",    want.data_valid,    out_item.data_valid);
        cmp_field("push_dropped",  want.push_dropped,  out_item.push_dropped);
        cmp_field("level",         want.level,         out_item.level);
        cmp_field("overflow_flag", want.overflow_flag, out_item.overflow_flag);
      end
      hold_draw = draw_wait(sink_quiet);
      out_stall <= (hold_draw != 0);
      sink_hold <= hold_draw;
    end else if (sink_hold > 0) begin
      out_stall <= (sink_hold > 1);
      sink_hold <= sink_hold - 1;
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d items accepted",
               cycle_count, ops_accepted, ops_total);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ch;
    int unsigned kind;
    int unsigned count;
    bit          one_ch;
    int unsigned target;

    // Directed: empty reads, byte extremes, peek versus pop, order, clear
    add_op(mcrb_pkg::OP_POP,   0, 8'h00);   // pop on empty ring
    add_op(mcrb_pkg::OP_PEEK,  0, 8'hFF);   // peek on empty ring
    add_op(mcrb_pkg::OP_PUSH,  0, 8'h00);
    add_op(mcrb_pkg::OP_PUSH,  0, 8'hFF);
    add_op(mcrb_pkg::OP_PEEK,  0, 8'h00);   // oldest byte stays in place
    add_op(mcrb_pkg::OP_POP,   0, 8'h00);
    add_op(mcrb_pkg::OP_POP,   0, 8'h00);
    add_op(mcrb_pkg::OP_POP,   0, 8'h00);   // pop on the drained, empty ring
    add_op(mcrb_pkg::OP_PUSH,  7, 8'hA5);
    add_op(mcrb_pkg::OP_PUSH,  7, 8'h5A);
    add_op(mcrb_pkg::OP_CLEAR, 7, 8'hFF);   // clear with bytes held
    add_op(mcrb_pkg::OP_PEEK,  7, 8'h00);   // nothing left after clear
    add_op(mcrb_pkg::OP_CLEAR, 3, 8'h00);   // clear on empty ring
    for (int i = 1; i < 7; i++) add_op(mcrb_pkg::OP_PUSH, i, 8'h11 * i);
    for (int i = 1; i < 7; i++) add_op(mcrb_pkg::OP_POP, i, 8'hFF);

    // Fill one ring past full (dropped pushes, sticky flag), then read it down
    // with mostly pops and some peeks, so the pointers wrap on later traffic.
    ch = $urandom_range(0, NUM_CH - 1);
    for (int i = 0; i < 262; i++)
      add_op(mcrb_pkg::OP_PUSH, ch, $urandom_range(0, 255));
    for (int i = 0; i < 262; i++)
      add_op(($urandom_range(0, 7) == 0) ? mcrb_pkg::OP_PEEK : mcrb_pkg::OP_POP, ch,
             $urandom_range(0, 255));

    // Random sequences: mostly short mixed bursts, now and then a fill, a
    // drain or a clear of one channel
    target = RANDOM_OPS;
    while (op_queue.size() < target) begin
      kind = $urandom_range(0, 19);
      ch   = $urandom_range(0, NUM_CH - 1);
      if (kind == 0) begin
        count = $urandom_range(255, 265);
        for (int i = 0; i < count; i++)
          add_op(mcrb_pkg::OP_PUSH, ch, $urandom_range(0, 255));
      end else if (kind == 1) begin
        count = $urandom_range(255, 265);
        for (int i = 0; i < count; i++)
          add_op(($urandom_range(0, 7) == 0) ? mcrb_pkg::OP_PEEK : mcrb_pkg::OP_POP, ch,
                 $urandom_range(0, 255));
      end else if (kind == 2) begin
        add_op(mcrb_pkg::OP_CLEAR, ch, $urandom_range(0, 255));
      end else begin
        count  = $urandom_range(4, 20);
        one_ch = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++)
          add_op(mixed_op(), one_ch ? ch : $urandom_range(0, NUM_CH - 1),
                 $urandom_range(0, 255));
      end
    end
    ops_total = op_queue.size();

    // Hold reset low at the start, then release it for good
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait on the falling edge so the counters and queue are settled
    while (ops_accepted < ops_total) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d items on %0d channels: %0d full-ring events, %0d dropped pushes,",
             ops_total, NUM_CH, n_full_seen, n_dropped);
    $display("  %0d reads with data, %0d reads of an empty ring, %0d clears",
             n_good_reads, n_empty_reads, n_clears);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
